// File: design/ipv4_longest_prefix_router_defines.svh
// Assertion macros shared by the router modules.
// Each macro expects clk and arst_n to be in scope.
`ifndef IPV4_LONGEST_PREFIX_ROUTER_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPR_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPR_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int MAX_ROUTES = 64;
	localparam int PORT_BITS  = 4;
	localparam int IDX_BITS   = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int CNT_BITS   = $clog2(MAX_ROUTES + 1);

	localparam logic [3:0] PORT_MASK = 4'((1 << PORT_BITS) - 1);

	localparam int IN_DATA_BITS  = 120;
	localparam int OUT_DATA_BITS = 48;

	// Kind of input word, carried on tuser.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_ROUTE = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_FULL    = 3'd1,
		ST_FWD     = 3'd2,
		ST_TTL     = 3'd3,
		ST_NOROUTE = 3'd4
	} status_t;

	// Input data word, last field in the lowest bits.
	typedef struct packed {
		logic [4:0]  pad;
		logic [7:0]  ttl_in;
		logic [31:0] dest_addr;
		logic [3:0]  route_port;
		logic [31:0] route_hop_addr;
		logic        route_has_hop;
		logic [5:0]  route_prefix_len;
		logic [31:0] route_prefix_addr;
	} in_word_t;

	// Result data word, last field in the lowest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [7:0]  ttl_out;
		logic [31:0] hop_addr_out;
		logic [3:0]  out_port;
	} out_word_t;

	// One route table entry.
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic        has_hop;
		logic [31:0] hop;
		logic [3:0]  port;
	} route_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic emit;
	} lpr_cmd_t;

	typedef struct packed {
		logic in_short;
		logic rd_last;
		logic out_free;
	} lpr_stat_t;

	function automatic logic [31:0] len_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'd0;
		end else begin
			m = 32'hFFFF_FFFF << (6'd32 - len);
		end
		return m;
	endfunction

endpackage

// File: design/lpr_ctrl.sv
`timescale 1ns / 1ps
`include "ipv4_longest_prefix_router_defines.svh"

module lpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lpr_pkg::lpr_stat_t st,
	output lpr_pkg::lpr_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DRAIN,
		FINISH
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == IDLE);

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == IDLE) && s_tvalid;
		cmd.rd   = (state_q == SCAN);
		cmd.emit = (state_q == FINISH) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= st.in_short ? FINISH : SCAN;
					end
				end
				SCAN: begin
					if (st.rd_last) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					state_q <= FINISH;
				end
				FINISH: begin
					if (st.out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`LPR_CHK_SAME(a_emit_free, cmd.emit, st.out_free, "result issued into a full output register")
	`LPR_CHK_NEXT(a_load_gap, cmd.load, !cmd.load, "two words accepted back to back")

endmodule

// File: design/lpr_dp.sv
`timescale 1ns / 1ps
`include "ipv4_longest_prefix_router_defines.svh"

module lpr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [lpr_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  logic                               s_tuser,
	input  lpr_pkg::lpr_cmd_t                  cmd,
	output lpr_pkg::lpr_stat_t                 st,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lpr_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	output logic [2:0]                         m_tuser
);

	lpr_pkg::route_t mem_q [lpr_pkg::MAX_ROUTES];

	lpr_pkg::in_word_t  in_w;
	lpr_pkg::route_t    new_route;
	lpr_pkg::route_t    rd_data_s1;
	lpr_pkg::out_word_t out_w;

	logic [lpr_pkg::CNT_BITS-1:0] count_q;
	logic [lpr_pkg::IDX_BITS-1:0] rd_idx_q;
	logic                         rd_vld_s1;

	logic        cmd_q;
	logic        full_q;
	logic [31:0] dest_q;
	logic [7:0]  ttl_q;

	logic        found_q;
	logic [5:0]  best_len_q;
	logic [3:0]  best_port_q;
	logic [31:0] best_hop_q;
	logic        best_has_hop_q;

	logic        out_vld_q;
	logic [2:0]  out_status_q;
	logic [3:0]  out_port_q;
	logic [31:0] out_hop_q;
	logic [7:0]  out_ttl_q;

	logic        in_add;
	logic        full_now;
	logic        do_write;
	logic [31:0] cmp_mask;
	logic        hit;
	logic        better;

	lpr_pkg::status_t res_status;

	assign in_w     = lpr_pkg::in_word_t'(s_tdata);
	assign in_add   = (s_tuser == lpr_pkg::CMD_ADD);
	assign full_now = (count_q >= lpr_pkg::CNT_BITS'(lpr_pkg::MAX_ROUTES));
	assign do_write = cmd.load && in_add && !full_now;

	always_comb begin
		new_route.prefix  = in_w.route_prefix_addr;
		new_route.len     = (in_w.route_prefix_len > 6'd32) ? 6'd32 : in_w.route_prefix_len;
		new_route.has_hop = in_w.route_has_hop;
		new_route.hop     = in_w.route_hop_addr;
		new_route.port    = in_w.route_port & lpr_pkg::PORT_MASK;
	end

	always_comb begin
		st          = '0;
		st.in_short = in_add || (in_w.ttl_in <= 8'd1) ||
			(count_q == lpr_pkg::CNT_BITS'(0));
		st.rd_last  = (rd_idx_q ==
			lpr_pkg::IDX_BITS'(count_q - lpr_pkg::CNT_BITS'(1)));
		st.out_free = !out_vld_q || m_tready;
	end

	// Table memory: one write port at the fill count, one registered read port.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[count_q[lpr_pkg::IDX_BITS-1:0]] <= new_route;
		end
		if (cmd.rd) begin
			rd_data_s1 <= mem_q[rd_idx_q];
		end
	end

	assign cmp_mask = lpr_pkg::len_mask(rd_data_s1.len);
	assign hit      = ((dest_q ^ rd_data_s1.prefix) & cmp_mask) == 32'd0;
	assign better   = !found_q || (rd_data_s1.len > best_len_q);

	always_comb begin
		if (cmd_q == lpr_pkg::CMD_ADD) begin
			res_status = full_q ? lpr_pkg::ST_FULL : lpr_pkg::ST_ADDED;
		end else if (ttl_q <= 8'd1) begin
			res_status = lpr_pkg::ST_TTL;
		end else if (found_q) begin
			res_status = lpr_pkg::ST_FWD;
		end else begin
			res_status = lpr_pkg::ST_NOROUTE;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (do_write) begin
				count_q <= count_q + lpr_pkg::CNT_BITS'(1);
			end
			if (cmd.load) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (cmd.rd) begin
					rd_idx_q <= rd_idx_q + lpr_pkg::IDX_BITS'(1);
				end
				if (rd_vld_s1 && hit && better) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= s_tuser;
			full_q <= full_now;
			dest_q <= in_w.dest_addr;
			ttl_q  <= in_w.ttl_in;
		end
		if (rd_vld_s1 && hit && better) begin
			best_len_q     <= rd_data_s1.len;
			best_port_q    <= rd_data_s1.port;
			best_hop_q     <= rd_data_s1.hop;
			best_has_hop_q <= rd_data_s1.has_hop;
		end
		if (cmd.emit) begin
			out_status_q <= res_status;
			if (res_status == lpr_pkg::ST_FWD) begin
				out_port_q <= best_port_q;
				out_hop_q  <= best_has_hop_q ? best_hop_q : dest_q;
				out_ttl_q  <= ttl_q - 8'd1;
			end else begin
				out_port_q <= 4'd0;
				out_hop_q  <= 32'd0;
				out_ttl_q  <= 8'd0;
			end
		end
	end

	always_comb begin
		out_w              = '0;
		out_w.out_port     = out_port_q;
		out_w.hop_addr_out = out_hop_q;
		out_w.ttl_out      = out_ttl_q;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_w;
	assign m_tuser  = out_status_q;

	`LPR_CHK_SAME(a_count_bound, 1'b1, count_q <= lpr_pkg::CNT_BITS'(lpr_pkg::MAX_ROUTES), "route count above table size")
	`LPR_CHK_SAME(a_rd_in_range, cmd.rd, lpr_pkg::CNT_BITS'(rd_idx_q) < count_q, "table read beyond stored routes")
	`LPR_CHK_NEXT(a_count_step, do_write, count_q == $past(count_q) + lpr_pkg::CNT_BITS'(1), "route add did not advance count")

endmodule

// File: design/ipv4_longest_prefix_router.sv
`timescale 1ns / 1ps
// An add word, a datagram with TTL of 1 or less and any datagram while the table is empty go from
// accept through FINISH into the output register. A datagram to look up passes SCAN over the N
// stored routes (up to 64), one entry per cycle on the table read port, then DRAIN and FINISH.
// A result waits in the output register; the next word is taken once the current one finishes.
// Reset (arst_n low, asynchronous) empties the table and drops any word in flight.

module ipv4_longest_prefix_router (
	input  logic        clk,
	input  logic        arst_n,

	// Slave side: route adds and datagrams.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata from bit 0 up: route_prefix_addr[31:0], route_prefix_len[37:32],
	// route_has_hop[38], route_hop_addr[70:39], route_port[74:71],
	// dest_addr[106:75], ttl_in[114:107], zero fill[119:115].
	input  logic [119:0] s_tdata,
	// s_tuser: cmd (0 add a route, 1 route a datagram).
	input  logic        s_tuser,

	// Master side: one result word per accepted word.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata from bit 0 up: out_port[3:0], hop_addr_out[35:4], ttl_out[43:36],
	// zero fill[47:44].
	output logic [47:0] m_tdata,
	// m_tuser: status (0 added, 1 table full, 2 forwarded, 3 TTL expired, 4 no route).
	output logic [2:0]  m_tuser
);

	// The controller sequences each word: accept, a table scan of one entry per
	// cycle, skipped for adds, TTLs of 1 or less and an empty table, the last
	// compare, and a hand-off into the output register. The datapath holds the
	// route table, the best-match tracking and the output register. The earliest route
	// wins a tie: a later entry replaces the best match only with a strictly longer prefix.

	lpr_pkg::lpr_cmd_t  cmd;
	lpr_pkg::lpr_stat_t st;

	lpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lpr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
